// ===== rtl/core/awsu_pkg.sv =====
// Package for the adaptive width sample unpacker: payload types, codes, escape tables.
package awsu_pkg;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] table_index;
      logic [7:0] table_value;
      logic [7:0] packed_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] sample;
      logic [1:0]  kind;
      logic        last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CODE,
      ST_FETCH,
      ST_SHIFT,
      ST_EVAL,
      ST_XLATE,
      ST_CALC,
      ST_EMIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_Y,
      PH_Z,
      PH_H,
      PH_E
   } phase_type;

   localparam logic [1:0] FUNC_TABLE = 2'd0;
   localparam logic [1:0] FUNC_DATA  = 2'd1;
   localparam logic [1:0] FUNC_BEGIN = 2'd2;

   localparam logic [1:0] KIND_SAMPLE    = 2'd0;
   localparam logic [1:0] KIND_END       = 2'd1;
   localparam logic [1:0] KIND_BAD_WIDTH = 2'd2;

   localparam logic [1:0] CSR_WIDE  = 2'd0;
   localparam logic [1:0] CSR_DELTA = 2'd1;
   localparam logic [1:0] CSR_ABS   = 2'd2;
   localparam logic [1:0] CSR_START = 2'd3;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned TABLE_WIDTH = 8;

   localparam logic [3:0]  MAX_RESULTS    = 4'd8;
   localparam logic [3:0]  BAD_WIDTH_MIN  = 4'd8;
   localparam logic [15:0] BASE_WIDE      = 16'hFFF0;
   localparam logic [15:0] BASE_NARROW    = 16'h00F8;
   localparam logic [15:0] FULL_WIDE      = 16'hFFFF;
   localparam logic [15:0] FULL_NARROW    = 16'h00FF;
   localparam logic [15:0] SIGN_FLIP      = 16'h8000;
   localparam logic [3:0]  LIT_MAX_WIDE   = 4'hF;
   localparam logic [3:0]  LIT_MAX_NARROW = 4'h7;
   localparam logic [4:0]  LIT_LEN_WIDE   = 5'd4;
   localparam logic [4:0]  LIT_LEN_NARROW = 5'd3;
   localparam logic [3:0]  WIDTH_MASK_WIDE   = 4'hF;
   localparam logic [3:0]  WIDTH_MASK_NARROW = 4'h7;

   localparam logic [15:0] THR_WIDE [16] = '{
      16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001E, 16'h003C, 16'h0078, 16'h00F0,
      16'h01F0, 16'h03F0, 16'h07F0, 16'h0FF0, 16'h1FF0, 16'h3FF0, 16'h7FF0, 16'hFFF0
   };
   localparam logic [2:0] EXT_WIDE [16] = '{
      3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
   };
   localparam logic [15:0] THR_NARROW [8] = '{
      16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001E, 16'h003C, 16'h0078, 16'h00F8
   };
   localparam logic [2:0] EXT_NARROW [8] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0
   };

   function automatic logic [15:0] esc_thr(input logic wide, input logic [3:0] w);
      esc_thr = wide ? THR_WIDE[w] : THR_NARROW[w[2:0]];
   endfunction

   function automatic logic [2:0] esc_ext(input logic wide, input logic [3:0] w);
      esc_ext = wide ? EXT_WIDE[w] : EXT_NARROW[w[2:0]];
   endfunction

endpackage

// ===== rtl/core/adaptive_width_sample_unpacker.sv =====
// Adaptive width sample unpacker: bit-serial code decoder with byte table and delta.
// A code is shifted in bit by bit in up to four fields, each fetched and then evaluated.
// Table loads write the byte table; a bad width on a begin or data beat gives a flag result.
// A data beat decodes codes until bits run out or the result cap is hit; one beat at a time.
// A stalled result stalls decoding; each result waits in a pending register so the last one of a beat can be marked.
// Reset (synchronous, active high) clears state, mode, valid flags, bit store, count, width and delta.
module adaptive_width_sample_unpacker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  awsu_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output awsu_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [3:0]                csr_data
);

   awsu_pkg::state_type       state_ff, state_in;
   awsu_pkg::phase_type       phase_ff, phase_in;
   logic                      wide_ff, wide_in;
   logic                      delta_ff, delta_in;
   logic                      abs_ff, abs_in;
   logic [3:0]                start_ff, start_in;
   logic [31:0]               store_ff, store_in;
   logic [5:0]                count_ff, count_in;
   logic [3:0]                cw_ff, cw_in;
   logic [15:0]               prev_ff, prev_in;
   logic [5:0]                pos_ff, pos_in;
   logic [3:0]                rd_ff, rd_in;
   logic [4:0]                len_ff, len_in;
   logic [15:0]               acc_ff, acc_in;
   logic [15:0]               y_ff, y_in;
   logic [15:0]               x_ff, x_in;
   logic [3:0]                nres_ff, nres_in;
   logic [15:0]               res_sample_ff, res_sample_in;
   logic [1:0]                res_kind_ff, res_kind_in;
   logic                      pend_valid_ff, pend_valid_in;
   awsu_pkg::rsp_payload_type pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   awsu_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        req_fire;
   logic [15:0] thr;
   logic [2:0]  ext;
   logic [19:0] nb;
   logic [31:0] shifted_store;
   logic [5:0]  left_count;
   logic [5:0]  bit_idx;
   logic        cur_bit;
   logic [39:0] ins_word;
   logic [6:0]  need_end;
   logic [15:0] zig;
   logic [15:0] val_base;
   logic [15:0] val_sum;
   logic [15:0] val_out;
   logic [7:0]  ram_q;
   logic [3:0]  lit_max;
   logic [4:0]  lit_len;

   awsu_ram #(
      .WIDTH(awsu_pkg::TABLE_WIDTH),
      .DEPTH(awsu_pkg::TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (req_fire && req_data.func == awsu_pkg::FUNC_TABLE),
      .wr_addr(req_data.table_index),
      .wr_data(req_data.table_value),
      .rd_addr(x_ff[7:0]),
      .rd_data(ram_q)
   );

   assign req_ready = (state_ff == awsu_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      thr           = awsu_pkg::esc_thr(wide_ff, cw_ff);
      ext           = awsu_pkg::esc_ext(wide_ff, cw_ff);
      nb            = ({4'd0, y_ff - thr} << ext) | {16'd0, acc_ff[3:0]};
      shifted_store = (pos_ff < 6'd32) ? (store_ff >> pos_ff[4:0]) : 32'd0;
      left_count    = count_ff - pos_ff;
      bit_idx       = pos_ff + {2'd0, rd_ff};
      cur_bit       = bit_idx[5] ? 1'b0 : store_ff[bit_idx[4:0]];
      ins_word      = {32'd0, req_data.packed_byte} << count_ff;
      need_end      = {1'b0, pos_ff} + {2'd0, len_ff};
      zig           = x_ff[0] ? ~{1'b0, x_ff[15:1]} : {1'b0, x_ff[15:1]};
      val_base      = wide_ff ? zig : {8'd0, ram_q};
      val_sum       = val_base + prev_ff;
      val_out       = delta_ff ? val_sum : val_base;
      if (wide_ff && !delta_ff && !abs_ff) begin
         val_out = val_out ^ awsu_pkg::SIGN_FLIP;
      end
      lit_max = wide_ff ? awsu_pkg::LIT_MAX_WIDE : awsu_pkg::LIT_MAX_NARROW;
      lit_len = wide_ff ? awsu_pkg::LIT_LEN_WIDE : awsu_pkg::LIT_LEN_NARROW;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      wide_in       = wide_ff;
      delta_in      = delta_ff;
      abs_in        = abs_ff;
      start_in      = start_ff;
      store_in      = store_ff;
      count_in      = count_ff;
      cw_in         = cw_ff;
      prev_in       = prev_ff;
      pos_in        = pos_ff;
      rd_in         = rd_ff;
      len_in        = len_ff;
      acc_in        = acc_ff;
      y_in          = y_ff;
      x_in          = x_ff;
      nres_in       = nres_ff;
      res_sample_in = res_sample_ff;
      res_kind_in   = res_kind_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            awsu_pkg::CSR_WIDE:  wide_in  = csr_data[0];
            awsu_pkg::CSR_DELTA: delta_in = csr_data[0];
            awsu_pkg::CSR_ABS:   abs_in   = csr_data[0];
            awsu_pkg::CSR_START: start_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         awsu_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.func)
                  awsu_pkg::FUNC_BEGIN: begin
                     store_in = '0;
                     count_in = '0;
                     prev_in  = '0;
                     cw_in    = start_ff;
                     if (!wide_ff && start_ff >= awsu_pkg::BAD_WIDTH_MIN) begin
                        pend_in       = '{sample: '0, kind: awsu_pkg::KIND_BAD_WIDTH, last: 1'b1};
                        pend_valid_in = 1'b1;
                        state_in      = awsu_pkg::ST_FINISH;
                     end
                  end
                  awsu_pkg::FUNC_DATA: begin
                     if (!wide_ff && cw_ff >= awsu_pkg::BAD_WIDTH_MIN) begin
                        pend_in       = '{sample: '0, kind: awsu_pkg::KIND_BAD_WIDTH, last: 1'b1};
                        pend_valid_in = 1'b1;
                        state_in      = awsu_pkg::ST_FINISH;
                     end else begin
                        store_in = store_ff | ins_word[31:0];
                        count_in = count_ff + 6'd8;
                        nres_in  = '0;
                        state_in = awsu_pkg::ST_CODE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         awsu_pkg::ST_CODE: begin
            if (nres_ff == awsu_pkg::MAX_RESULTS) begin
               state_in = awsu_pkg::ST_FINISH;
            end else begin
               phase_in = awsu_pkg::PH_Y;
               len_in   = {1'b0, cw_ff} + 5'd1;
               pos_in   = '0;
               state_in = awsu_pkg::ST_FETCH;
            end
         end
         awsu_pkg::ST_FETCH: begin
            acc_in = '0;
            if (len_ff == 5'd0) begin
               state_in = awsu_pkg::ST_EVAL;
            end else if (need_end > {1'b0, count_ff}) begin
               state_in = awsu_pkg::ST_FINISH;
            end else begin
               rd_in    = 4'(len_ff - 5'd1);
               state_in = awsu_pkg::ST_SHIFT;
            end
         end
         awsu_pkg::ST_SHIFT: begin
            acc_in = {acc_ff[14:0], cur_bit};
            if (rd_ff == 4'd0) begin
               pos_in   = need_end[5:0];
               state_in = awsu_pkg::ST_EVAL;
            end else begin
               rd_in = rd_ff - 4'd1;
            end
         end
         awsu_pkg::ST_EVAL: begin
            case (phase_ff)
               awsu_pkg::PH_Y: begin
                  if (acc_ff >= thr) begin
                     y_in     = acc_ff;
                     phase_in = awsu_pkg::PH_Z;
                     len_in   = {2'd0, ext};
                     state_in = awsu_pkg::ST_FETCH;
                  end else begin
                     store_in = shifted_store;
                     count_in = left_count;
                     x_in     = acc_ff;
                     state_in = awsu_pkg::ST_XLATE;
                  end
               end
               awsu_pkg::PH_Z: begin
                  if (nb != {16'd0, cw_ff}) begin
                     store_in = shifted_store;
                     count_in = left_count;
                     cw_in    = nb[3:0] & (wide_ff ? awsu_pkg::WIDTH_MASK_WIDE
                                                   : awsu_pkg::WIDTH_MASK_NARROW);
                     state_in = awsu_pkg::ST_CODE;
                  end else begin
                     phase_in = awsu_pkg::PH_H;
                     len_in   = lit_len;
                     state_in = awsu_pkg::ST_FETCH;
                  end
               end
               awsu_pkg::PH_H: begin
                  if (acc_ff[3:0] == lit_max) begin
                     phase_in = awsu_pkg::PH_E;
                     len_in   = 5'd1;
                     state_in = awsu_pkg::ST_FETCH;
                  end else begin
                     store_in = shifted_store;
                     count_in = left_count;
                     x_in     = (wide_ff ? awsu_pkg::BASE_WIDE : awsu_pkg::BASE_NARROW)
                                + {12'd0, acc_ff[3:0]};
                     state_in = awsu_pkg::ST_XLATE;
                  end
               end
               default: begin
                  store_in = shifted_store;
                  count_in = left_count;
                  if (acc_ff[0]) begin
                     res_sample_in = '0;
                     res_kind_in   = awsu_pkg::KIND_END;
                     state_in      = awsu_pkg::ST_EMIT;
                  end else begin
                     x_in     = wide_ff ? awsu_pkg::FULL_WIDE : awsu_pkg::FULL_NARROW;
                     state_in = awsu_pkg::ST_XLATE;
                  end
               end
            endcase
         end
         awsu_pkg::ST_XLATE: begin
            state_in = awsu_pkg::ST_CALC;
         end
         awsu_pkg::ST_CALC: begin
            if (delta_ff) begin
               prev_in = val_sum;
            end
            res_sample_in = wide_ff ? val_out : {8'd0, val_out[7:0]};
            res_kind_in   = awsu_pkg::KIND_SAMPLE;
            state_in      = awsu_pkg::ST_EMIT;
         end
         awsu_pkg::ST_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_data_in  = '{sample: pend_ff.sample, kind: pend_ff.kind, last: 1'b0};
                  rsp_valid_in = 1'b1;
               end
               pend_in       = '{sample: res_sample_ff, kind: res_kind_ff, last: 1'b0};
               pend_valid_in = 1'b1;
               nres_in       = nres_ff + 4'd1;
               state_in      = awsu_pkg::ST_CODE;
            end
         end
         awsu_pkg::ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = awsu_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_data_in   = '{sample: pend_ff.sample, kind: pend_ff.kind, last: 1'b1};
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = awsu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = awsu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= awsu_pkg::ST_IDLE;
         wide_ff       <= 1'b0;
         delta_ff      <= 1'b0;
         abs_ff        <= 1'b0;
         start_ff      <= '0;
         store_ff      <= '0;
         count_ff      <= '0;
         cw_ff         <= '0;
         prev_ff       <= '0;
         nres_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wide_ff       <= wide_in;
         delta_ff      <= delta_in;
         abs_ff        <= abs_in;
         start_ff      <= start_in;
         store_ff      <= store_in;
         count_ff      <= count_in;
         cw_ff         <= cw_in;
         prev_ff       <= prev_in;
         nres_ff       <= nres_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      pos_ff        <= pos_in;
      rd_ff         <= rd_in;
      len_ff        <= len_in;
      acc_ff        <= acc_in;
      y_ff          <= y_in;
      x_ff          <= x_in;
      res_sample_ff <= res_sample_in;
      res_kind_ff   <= res_kind_in;
      pend_ff       <= pend_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== rtl/core/awsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module awsu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/unpack_checker.sv =====
// Checker for the sample unpacker: tracks config and input beats, predicts and compares results.
`timescale 1ns / 100ps
module unpack_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  awsu_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  awsu_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [3:0]                csr_data,
   output int                        mismatches,
   output int                        outstanding
);
   import awsu_pkg::*;

   typedef enum {STEP_STARVED, STEP_SILENT, STEP_EMIT} step_kind_type;

   logic            mode_wide;
   logic            mode_delta;
   logic            mode_abs;
   logic [3:0]      width_init;
   logic [3:0]      cur_width;
   logic [31:0]     fifo_bits;
   int unsigned     fifo_len;
   int unsigned     scan_pos;
   logic [15:0]     delta_acc;
   logic [7:0]      sample_lut [256];
   rsp_payload_type due_q [$];
   rsp_payload_type head;

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic bit grab(input int unsigned n, output logic [31:0] val);
      val = '0;
      if (scan_pos + n > fifo_len) return 1'b0;
      if (n != 0) val = (fifo_bits >> scan_pos) & ((32'd1 << n) - 32'd1);
      scan_pos += n;
      return 1'b1;
   endfunction

   function automatic void drop_bits(input int unsigned n);
      fifo_bits = fifo_bits >> n;
      fifo_len -= n;
   endfunction

   // one code off the front of the bit buffer
   function automatic step_kind_type decode_code(output logic [15:0] smp,
                                                 output logic [1:0] knd);
      int unsigned w, ww, thr, ext, lit_len, lit_top, nb;
      logic [31:0] y, z, h, e, x;
      smp = '0;
      knd = KIND_SAMPLE;
      scan_pos = 0;
      w = cur_width;
      ww = w & 7;
      if (mode_wide) begin
         if (w < 4) begin
            thr = (1 << (w + 1)) - 1;
            ext = 4;
         end else if (w < 8) begin
            thr = 15 << (w - 3);
            ext = 7 - w;
         end else begin
            thr = ((1 << (w + 1)) - 1) & 32'hFFF0;
            ext = 0;
         end
         lit_len = 4;
         lit_top = 15;
      end else begin
         if (ww < 4) begin
            thr = (1 << (ww + 1)) - 1;
            ext = 3;
         end else if (ww < 7) begin
            thr = 15 << (ww - 3);
            ext = 6 - ww;
         end else begin
            thr = 32'hF8;
            ext = 0;
         end
         lit_len = 3;
         lit_top = 7;
      end
      if (!grab(w + 1, y)) return STEP_STARVED;
      if (y >= thr) begin
         if (!grab(ext, z)) return STEP_STARVED;
         nb = ((y - thr) << ext) | z;
         if (nb != w) begin
            drop_bits(scan_pos);
            cur_width = mode_wide ? nb[3:0] : {1'b0, nb[2:0]};
            return STEP_SILENT;
         end
         if (!grab(lit_len, h)) return STEP_STARVED;
         if (h == lit_top) begin
            if (!grab(1, e)) return STEP_STARVED;
            if (e[0]) begin
               drop_bits(scan_pos);
               knd = KIND_END;
               return STEP_EMIT;
            end
            x = mode_wide ? 32'hFFFF : 32'hFF;
         end else begin
            x = (mode_wide ? 32'hFFF0 : 32'hF8) + h;
         end
      end else begin
         x = y;
      end
      drop_bits(scan_pos);
      if (mode_wide) begin
         x = x[0] ? 32'hFFFF_FFFF - (x >> 1) : x >> 1;
         if (mode_delta) begin
            delta_acc = x[15:0] + delta_acc;
            x = {16'h0, delta_acc};
         end else if (!mode_abs) begin
            x = x ^ 32'h8000;
         end
         smp = x[15:0];
      end else begin
         x = {24'h0, sample_lut[x[7:0]]};
         if (mode_delta) begin
            delta_acc = x[15:0] + delta_acc;
            x = {16'h0, delta_acc};
         end
         smp = {8'h00, x[7:0]};
      end
      return STEP_EMIT;
   endfunction

   task automatic predict_beat(input req_payload_type beat);
      rsp_payload_type made [8];
      int              n;
      bit              more;
      step_kind_type   st;
      logic [15:0]     smp;
      logic [1:0]      knd;
      n = 0;
      case (beat.func)
         FUNC_TABLE: sample_lut[beat.table_index] = beat.table_value;
         FUNC_BEGIN: begin
            fifo_bits = '0;
            fifo_len = 0;
            delta_acc = '0;
            cur_width = width_init;
            if (!mode_wide && width_init >= BAD_WIDTH_MIN) begin
               made[0].sample = '0;
               made[0].kind = KIND_BAD_WIDTH;
               n = 1;
            end
         end
         FUNC_DATA: begin
            if (!mode_wide && cur_width >= BAD_WIDTH_MIN) begin
               made[0].sample = '0;
               made[0].kind = KIND_BAD_WIDTH;
               n = 1;
            end else begin
               fifo_bits = fifo_bits | ({24'h0, beat.packed_byte} << fifo_len);
               fifo_len += 8;
               more = 1'b1;
               while (more && n < MAX_RESULTS) begin
                  st = decode_code(smp, knd);
                  if (st == STEP_STARVED) begin
                     more = 1'b0;
                  end else if (st == STEP_EMIT) begin
                     made[n].sample = smp;
                     made[n].kind = knd;
                     n++;
                  end
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < n; i++) begin
         made[i].last = (i == n - 1);
         due_q.push_back(made[i]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_wide = 1'b0;
         mode_delta = 1'b0;
         mode_abs = 1'b0;
         width_init = '0;
         cur_width = '0;
         fifo_bits = '0;
         fifo_len = 0;
         delta_acc = '0;
         due_q.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDE:  mode_wide = csr_data[0];
               CSR_DELTA: mode_delta = csr_data[0];
               CSR_ABS:   mode_abs = csr_data[0];
               CSR_START: width_init = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_beat(req_data);
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               report_mismatch($sformatf("result beat with none due: sample %h kind %0d last %0b",
                                         rsp_data.sample, rsp_data.kind, rsp_data.last));
            end else begin
               head = due_q.pop_front();
               if (rsp_data.sample !== head.sample)
                  report_mismatch($sformatf("sample %h, expected %h",
                                            rsp_data.sample, head.sample));
               if (rsp_data.kind !== head.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_data.kind, head.kind));
               if (rsp_data.last !== head.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_data.last, head.last));
            end
         end
      end
      outstanding = due_q.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the sample unpacker: clock, reset, stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps
module tb;
   import awsu_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 3000;
   localparam int         SETTLE      = 200;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [3:0]      csr_data = '0;

   int mismatches;
   int outstanding;
   int quiet = 0;
   int hold = 0;
   bit calm = 1'b0;

   always #2 clock = ~clock;

   adaptive_width_sample_unpacker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   unpack_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // result-side backpressure in bursts
   always @(negedge clock) begin
      if (hold > 0) begin
         hold <= hold - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         hold <= $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic push_beat(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] val,
                            input logic [7:0] b);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_data.func = op;
      req_data.table_index = idx;
      req_data.table_value = val;
      req_data.packed_byte = b;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic push_data(input logic [7:0] b);
      push_beat(FUNC_DATA, 8'($urandom), 8'($urandom), b);
   endtask

   task automatic push_op(input logic [1:0] op);
      push_beat(op, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
      @(negedge clock);
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_mode(input bit wide, input bit delta, input bit keep_abs,
                           input logic [3:0] start);
      write_reg(CSR_WIDE, {3'b000, wide});
      write_reg(CSR_DELTA, {3'b000, delta});
      write_reg(CSR_ABS, {3'b000, keep_abs});
      write_reg(CSR_START, start);
   endtask

   // hold off until every result is back and the decoder has drained
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic random_phase(input int beats);
      bit         wide;
      bit         delta;
      bit         keep_abs;
      logic [3:0] start;
      logic [7:0] b;
      int         roll;
      wide = $urandom_range(0, 1);
      delta = $urandom_range(0, 1);
      keep_abs = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
         0: start = 4'd0;
         1: start = wide ? 4'd15 : 4'd7;
         default: start = wide ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
      endcase
      if (!wide && $urandom_range(0, 9) == 0) start = 4'($urandom_range(8, 15));
      set_mode(wide, delta, keep_abs, start);
      // occasionally keep the old stream so buffered bits see the new mode
      if ($urandom_range(0, 4) != 0) push_op(FUNC_BEGIN);
      repeat (beats) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            case ($urandom_range(0, 9))
               0, 1: b = 8'hFF;
               2: b = 8'h00;
               default: b = 8'($urandom);
            endcase
            push_data(b);
         end else if (roll < 88) begin
            push_beat(FUNC_TABLE, 8'($urandom), 8'($urandom), 8'($urandom));
         end else if (roll < 95) begin
            push_op(FUNC_BEGIN);
         end else begin
            push_op(FUNC_UNUSED);
         end
      end
      quiesce();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 256; i++) push_beat(FUNC_TABLE, 8'(i), 8'($urandom), 8'($urandom));
      quiesce();

      // narrow, one-bit codes: full result cap, end escape, width changes
      set_mode(1'b0, 1'b0, 1'b0, 4'd0);
      push_op(FUNC_BEGIN);
      push_data(8'h00);
      push_data(8'hF1);
      push_data(8'h03);
      push_data(8'hFF);
      push_op(FUNC_UNUSED);
      quiesce();

      // bad start width in narrow mode
      set_mode(1'b0, 1'b0, 1'b0, 4'd8);
      push_op(FUNC_BEGIN);
      push_data(8'h5A);
      quiesce();
      set_mode(1'b0, 1'b0, 1'b0, 4'd15);
      push_op(FUNC_BEGIN);
      push_data(8'hA5);
      quiesce();

      // wide, 16-bit codes: end escape via all-ones, sign flip
      set_mode(1'b1, 1'b0, 1'b0, 4'd15);
      push_op(FUNC_BEGIN);
      push_data(8'hFF);
      push_data(8'hFF);
      push_data(8'hFF);
      push_data(8'h00);
      push_data(8'h80);
      quiesce();

      // mode change with bits still buffered
      set_mode(1'b1, 1'b1, 1'b0, 4'd0);
      push_data(8'h00);
      push_data(8'hA5);
      quiesce();

      set_mode(1'b0, 1'b1, 1'b1, 4'd7);
      push_op(FUNC_BEGIN);
      push_data(8'hFF);
      push_data(8'h7F);
      push_data(8'h00);
      quiesce();

      set_mode(1'b1, 1'b0, 1'b1, 4'd3);
      push_data(8'h3C);
      push_op(FUNC_BEGIN);
      push_data(8'hFF);
      push_data(8'h10);
      quiesce();

      for (int p = 0; p < 8; p++) begin
         calm = (p >= 6);
         random_phase(14);
      end

      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== adaptive_width_sample_unpacker.f =====
rtl/core/awsu_pkg.sv
rtl/core/awsu_ram.sv
rtl/core/adaptive_width_sample_unpacker.sv
sim/unpack_checker.sv
sim/tb.sv
